>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> hdl/tbdrp_pkg.sv
package tbdrp_pkg;

    localparam int DimW  = 14;
    localparam int RowW  = 14;
    localparam int OutW  = 13;
    localparam int SlotOutW = 3;

    localparam int InTdataW  = 64;
    localparam int OutTdataW = 80;

    // One frame notice as taken from the input stream.
    typedef struct packed {
        logic signed [14:0] dirty_end;
        logic signed [14:0] dirty_first;
        logic [DimW-1:0]    frame_height;
        logic [DimW-1:0]    frame_width;
    } notice_t;

    // Copy command handed downstream.
    typedef struct packed {
        logic [SlotOutW-1:0] previous_front;
        logic                row_by_row;
        logic [DimW-1:0]     source_pitch;
        logic [OutW-1:0]     stored_height;
        logic [OutW-1:0]     stored_width;
        logic [OutW-1:0]     copy_end_row;
        logic [OutW-1:0]     copy_first_row;
        logic [SlotOutW-1:0] target_slot;
    } command_t;

    // Handshake between the input register and the slot stage.
    typedef struct packed {
        logic    valid;
        notice_t notice;
    } stage_t;

endpackage

>>> hdl/triple_buffer_dirty_row_publisher_top.sv
// Channel   Dir  Width  Carries
// s_axis    in   64     frame notice: width, height, dirty first, dirty end
// m_axis    out  80     copy command for the slot made front
//
// One notice per cycle is taken when the output is drained every cycle.
// The path has two registers: input register, then slot logic into the result register.
// Notices of zero width or height are consumed without a result.
// A stalled result holds a non-empty notice in the input register; one more notice waits there.
// rst_n clears slot rotation, kept size and owed rows at once.
`include "assert_macros.svh"

module triple_buffer_dirty_row_publisher_top
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int SLOT_COUNT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] frame_width, [27:14] frame_height, [42:28] dirty_first,
    // [57:43] dirty_end, [63:58] zero
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] target_slot, [15:3] copy_first_row, [28:16] copy_end_row,
    // [41:29] stored_width, [54:42] stored_height, [68:55] source_pitch,
    // [69] row_by_row, [72:70] previous_front, [79:73] zero
    output logic [79:0] m_axis_tdata
);
    import tbdrp_pkg::*;

    stage_t   stage;
    logic     advance;
    command_t command;

    tbdrp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .advance  (advance),
        .stage    (stage)
    );

    tbdrp_core
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SLOT_COUNT (SLOT_COUNT)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .command   (command)
    );

    assign m_axis_tdata = {{(OutTdataW - $bits(command_t)){1'b0}}, command};

    // Target never equals the slot it displaces.
    `ASSERT_IMPL(a_target_new, m_axis_tvalid, m_axis_tdata[2:0] != m_axis_tdata[72:70], "target equals previous front")
    // Row-by-row only when the source is wider than what is kept.
    `ASSERT_IMPL(a_row_flag, m_axis_tvalid && m_axis_tdata[69], m_axis_tdata[68:55] > {1'b0, m_axis_tdata[41:29]}, "row flag without crop")
    // Input side stalls only behind a stalled result.
    `ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule

>>> hdl/tbdrp_in_stage.sv
module tbdrp_in_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tbdrp_pkg::InTdataW-1:0]  s_tdata,
    input  logic                            advance,
    output tbdrp_pkg::stage_t               stage
);
    import tbdrp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    notice_t notice_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until the next transaction is taken.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            notice_reg <= notice_t'(s_tdata[$bits(notice_t)-1:0]);
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.notice = notice_reg;

endmodule

>>> hdl/tbdrp_core.sv
module tbdrp_core
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int SLOT_COUNT = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tbdrp_pkg::stage_t   stage,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output tbdrp_pkg::command_t command
);
    import tbdrp_pkg::*;

    localparam int SlotW = $clog2(SLOT_COUNT);
    localparam logic [DimW-1:0] MaxW = DimW'(MAX_WIDTH);
    localparam logic [DimW-1:0] MaxH = DimW'(MAX_HEIGHT);

    logic [SlotW-1:0] front_reg,  front_next;
    logic [SlotW-1:0] prior_reg,  prior_next;
    logic [DimW-1:0]  kept_w_reg, kept_w_next;
    logic [DimW-1:0]  kept_h_reg, kept_h_next;
    logic [SLOT_COUNT-1:0] stale_reg, stale_next;
    logic [RowW-1:0]  owed_first_reg [SLOT_COUNT];
    logic [RowW-1:0]  owed_first_next[SLOT_COUNT];
    logic [RowW-1:0]  owed_end_reg   [SLOT_COUNT];
    logic [RowW-1:0]  owed_end_next  [SLOT_COUNT];
    logic             out_valid_reg, out_valid_next;
    command_t         command_reg,   command_next;

    logic [DimW-1:0]  src_w, src_h, w, h;
    logic [RowW-1:0]  top_raw, bot_raw, top, bot;
    logic [RowW-1:0]  cf, ce;
    logic             drop, whole, resize, fire;
    logic [SLOT_COUNT-1:0] stale_eff;
    logic [SlotW-1:0] target;
    logic             found;

    assign src_w = stage.notice.frame_width;
    assign src_h = stage.notice.frame_height;
    assign drop  = (src_w == '0) || (src_h == '0);

    assign advance = stage.valid && (drop || !out_valid_reg || out_ready);
    assign fire    = advance && !drop;

    always_comb
    begin
        w = (src_w > MaxW) ? MaxW : src_w;
        h = (src_h > MaxH) ? MaxH : src_h;

        // Empty or negative range: take the whole frame.
        whole = (stage.notice.dirty_first < 0) ||
                (stage.notice.dirty_end <= stage.notice.dirty_first);
        top_raw = whole ? '0 : RowW'(stage.notice.dirty_first[13:0]);
        bot_raw = whole ? h  : RowW'(stage.notice.dirty_end[13:0]);
        top = (top_raw > h) ? h : top_raw;
        bot = (bot_raw > h) ? h : bot_raw;

        resize    = (w != kept_w_reg) || (h != kept_h_reg);
        stale_eff = resize ? '1 : stale_reg;

        // First slot that is neither front nor previous front.
        target = '0;
        found  = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!found && SlotW'(i) != front_reg && SlotW'(i) != prior_reg)
            begin
                target = SlotW'(i);
                found  = 1'b1;
            end
        end

        cf = top;
        ce = bot;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (SlotW'(i) == target)
            begin
                if (stale_eff[i])
                begin
                    cf = '0;
                    ce = h;
                end
                else if (owed_end_reg[i] > owed_first_reg[i])
                begin
                    if (owed_first_reg[i] < top)
                    begin
                        cf = owed_first_reg[i];
                    end
                    if (owed_end_reg[i] > bot)
                    begin
                        ce = owed_end_reg[i];
                    end
                end
            end
        end

        front_next  = front_reg;
        prior_next  = prior_reg;
        kept_w_next = kept_w_reg;
        kept_h_next = kept_h_reg;
        stale_next  = stale_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            owed_first_next[i] = owed_first_reg[i];
            owed_end_next[i]   = owed_end_reg[i];
        end

        if (fire)
        begin
            front_next  = target;
            prior_next  = front_reg;
            kept_w_next = w;
            kept_h_next = h;
            stale_next  = stale_eff;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (SlotW'(i) == target)
                begin
                    stale_next[i]      = 1'b0;
                    owed_first_next[i] = '0;
                    owed_end_next[i]   = '0;
                end
                else if (owed_end_reg[i] > owed_first_reg[i])
                begin
                    // Widen the existing debt.
                    if (top < owed_first_reg[i])
                    begin
                        owed_first_next[i] = top;
                    end
                    if (bot > owed_end_reg[i])
                    begin
                        owed_end_next[i] = bot;
                    end
                end
                else
                begin
                    owed_first_next[i] = top;
                    owed_end_next[i]   = bot;
                end
            end
        end

        command_next.target_slot    = SlotOutW'(target);
        command_next.copy_first_row = cf[OutW-1:0];
        command_next.copy_end_row   = ce[OutW-1:0];
        command_next.stored_width   = w[OutW-1:0];
        command_next.stored_height  = h[OutW-1:0];
        command_next.source_pitch   = src_w;
        command_next.row_by_row     = (src_w != w);
        command_next.previous_front = SlotOutW'(front_reg);

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            prior_reg     <= SlotW'(SLOT_COUNT - 1);
            kept_w_reg    <= '0;
            kept_h_reg    <= '0;
            stale_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owed_first_reg[i] <= '0;
                owed_end_reg[i]   <= '0;
            end
        end
        else
        begin
            front_reg     <= front_next;
            prior_reg     <= prior_next;
            kept_w_reg    <= kept_w_next;
            kept_h_reg    <= kept_h_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owed_first_reg[i] <= owed_first_next[i];
                owed_end_reg[i]   <= owed_end_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            command_reg <= command_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;

endmodule
